// ===== rtl/whlm_pkg.sv =====
// Shared types and constants for the wear-leveled hour meter.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package whlm_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [31:0] ERASED_WORD    = 32'hFFFF_FFFF;
  localparam logic [31:0] THRESHOLD_INIT = 32'd1000000;
  localparam logic [31:0] PERIOD_INIT    = 32'd360000000;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_THR,
    ST_ADD,
    ST_PER,
    ST_INC,
    ST_SCAN,
    ST_WCHK,
    ST_DONE
  } state_t;

  // Operation applied to the shared compare and add unit.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD_CMP,
    OP_THR_CMP,
    OP_ACC_ADD,
    OP_PER_CMP,
    OP_INC_ADD,
    OP_MIN_CMP,
    OP_WR_CMP
  } op_t;

  typedef struct packed {
    logic accept;
    logic func;
    logic gt;
    logic scan_last;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic in_ready;
    op_t  op;
    logic result_load;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/whlm_slot_file.sv =====
// Slot copies of the non-volatile words, one write and one read port.
// Depends on whlm_pkg for the slot count and index width.
`default_nettype none
module whlm_slot_file
  import whlm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [31:0]      wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [31:0]      rd_data
);

  logic [31:0] slots [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots[i] <= '0;
      end
    end else if (wr_en) begin
      slots[wr_addr] <= wr_data;
    end
  end

  assign rd_data = slots[rd_addr];

endmodule
`default_nettype wire

// ===== rtl/whlm_ctrl.sv =====
// Sequencer of the hour meter: walks one request through the shared unit.
// Depends on whlm_pkg for the state, operation and status types.
`default_nettype none
module whlm_ctrl
  import whlm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire status_t stat,
  output ctrl_t        ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (stat.accept) begin
          state_next = stat.func ? ST_THR : ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_DONE;
      ST_THR:  state_next = stat.gt ? ST_ADD : ST_DONE;
      ST_ADD:  state_next = ST_PER;
      ST_PER:  state_next = stat.gt ? ST_INC : ST_DONE;
      ST_INC:  state_next = (SLOT_COUNT > 1) ? ST_SCAN : ST_WCHK;
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = ST_WCHK;
        end
      end
      ST_WCHK: state_next = ST_DONE;
      ST_DONE: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '{in_ready: 1'b0, op: OP_NONE, result_load: 1'b0};
    unique case (state)
      ST_IDLE: ctl.in_ready    = 1'b1;
      ST_LOAD: ctl.op          = OP_LOAD_CMP;
      ST_THR:  ctl.op          = OP_THR_CMP;
      ST_ADD:  ctl.op          = OP_ACC_ADD;
      ST_PER:  ctl.op          = OP_PER_CMP;
      ST_INC:  ctl.op          = OP_INC_ADD;
      ST_SCAN: ctl.op          = OP_MIN_CMP;
      ST_WCHK: ctl.op          = OP_WR_CMP;
      ST_DONE: ctl.result_load = stat.out_free;
      default: ctl.op          = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/wear_leveled_hour_meter_unit.sv =====
// One request at a time: a load checks and stores the slot word; a sample is compared with
// the threshold and, if above, added to the accumulator and compared with the period; a
// rollover then increments the count, scans the slots for the minimum and checks the write.
// No new request is taken before the result is handed on. The single shared 33-bit unit
// compares or adds one step per cycle; the slot minimum scan takes one slot per cycle.
// Reset clears all slots, count and accumulator at once and restores register defaults.
`default_nettype none
module wear_leveled_hour_meter_unit
  import whlm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 func,
  input  wire logic [3:0]           slot_index,
  input  wire logic [31:0]          slot_word,
  input  wire logic [31:0]          timer_us,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      timer_clear,
  output logic [31:0]               hours_tenths,
  output logic                      write_enable,
  output logic [3:0]                write_index,
  output logic [31:0]               write_value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  status_t stat;
  ctrl_t   ctl;

  logic [31:0] threshold, period;
  logic [31:0] hour_count;
  logic [32:0] acc;
  logic [31:0] word_reg, timer_reg;
  logic [3:0]  idx_reg;
  logic [31:0] min_val;
  logic [IDX_W-1:0] min_idx, cnt;
  logic        clr_p, we_p;
  logic [IDX_W-1:0] widx_p;
  logic [31:0] wval_p;

  logic [32:0] op_a, op_b, sum;
  logic        gt;
  logic        slot_we;
  logic [IDX_W-1:0] slot_waddr;
  logic [31:0] slot_wdata, slot_rdata;
  logic        accept, idx_ok, below_ceiling;

  assign accept    = in_valid && in_ready;
  assign in_ready  = ctl.in_ready;
  assign cfg_ready = 1'b1;

  assign idx_ok        = {1'b0, idx_reg} < 5'(SLOT_COUNT);
  assign below_ceiling = hour_count[31:1] != '1;

  // Shared compare and add unit; the sequencer picks its operands.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (ctl.op)
      OP_LOAD_CMP: begin op_a = {1'b0, word_reg};   op_b = {1'b0, hour_count}; end
      OP_THR_CMP:  begin op_a = {1'b0, timer_reg};  op_b = {1'b0, threshold};  end
      OP_ACC_ADD:  begin op_a = acc;                op_b = {1'b0, timer_reg};  end
      OP_PER_CMP:  begin op_a = acc;                op_b = {1'b0, period};     end
      OP_INC_ADD:  begin op_a = {1'b0, hour_count}; op_b = 33'd1;              end
      OP_MIN_CMP:  begin op_a = {1'b0, min_val};    op_b = {1'b0, slot_rdata}; end
      OP_WR_CMP:   begin op_a = {1'b0, hour_count}; op_b = {1'b0, min_val};    end
      OP_NONE:     begin op_a = '0;                 op_b = '0;                 end
      default:     begin op_a = '0;                 op_b = '0;                 end
    endcase
  end

  assign gt  = op_a > op_b;
  assign sum = op_a + op_b;

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = min_idx;
    slot_wdata = hour_count;
    if (ctl.op == OP_LOAD_CMP) begin
      slot_we    = idx_ok;
      slot_waddr = idx_reg[IDX_W-1:0];
      slot_wdata = word_reg;
    end else if (ctl.op == OP_WR_CMP) begin
      slot_we = gt;
    end
  end

  whlm_slot_file u_slots (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (slot_we),
    .wr_addr (slot_waddr),
    .wr_data (slot_wdata),
    .rd_addr (cnt),
    .rd_data (slot_rdata)
  );

  assign stat = '{accept:    accept,
                  func:      func,
                  gt:        gt,
                  scan_last: cnt == IDX_W'(SLOT_COUNT - 1),
                  out_free:  !out_valid || out_ready};

  whlm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_INIT;
      period    <= PERIOD_INIT;
    end else if (cfg_valid) begin
      if (cfg_index == REG_THRESHOLD) begin
        threshold <= cfg_data;
      end else if (cfg_index == REG_PERIOD) begin
        period <= cfg_data;
      end
    end
  end

  // Request capture; an erased word is taken as zero from the start.
  always_ff @(posedge clk) begin
    if (accept) begin
      word_reg  <= (slot_word == ERASED_WORD) ? '0 : slot_word;
      idx_reg   <= slot_index;
      timer_reg <= timer_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count <= '0;
      acc        <= '0;
      cnt        <= '0;
      clr_p      <= 1'b0;
      we_p       <= 1'b0;
      widx_p     <= '0;
      wval_p     <= '0;
    end else begin
      if (accept) begin
        cnt    <= '0;
        clr_p  <= 1'b0;
        we_p   <= 1'b0;
        widx_p <= '0;
        wval_p <= '0;
      end
      unique case (ctl.op)
        OP_LOAD_CMP: begin
          if (idx_ok && gt) begin
            hour_count <= word_reg;
          end
        end
        OP_THR_CMP: clr_p <= gt;
        OP_ACC_ADD: acc <= sum;
        OP_PER_CMP: begin
          if (gt) begin
            acc <= '0;
          end
        end
        OP_INC_ADD: begin
          if (below_ceiling) begin
            hour_count <= sum[31:0];
          end
          cnt <= IDX_W'(1);
        end
        OP_MIN_CMP: cnt <= cnt + IDX_W'(1);
        OP_WR_CMP: begin
          if (gt) begin
            we_p   <= 1'b1;
            widx_p <= min_idx;
            wval_p <= hour_count;
          end
        end
        OP_NONE: ;
        default: ;
      endcase
    end
  end

  // Running minimum of the scan; slot zero seeds it during the increment step.
  always_ff @(posedge clk) begin
    if (ctl.op == OP_INC_ADD) begin
      min_val <= slot_rdata;
      min_idx <= '0;
    end else if (ctl.op == OP_MIN_CMP && gt) begin
      min_val <= slot_rdata;
      min_idx <= cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.result_load) begin
      timer_clear  <= clr_p;
      hours_tenths <= hour_count;
      write_enable <= we_p;
      write_index  <= 4'(widx_p);
      write_value  <= wval_p;
    end
  end

  a_write_is_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> write_value == hours_tenths)
    else $error("slot write value differs from reported count");

  a_write_needs_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_enable |-> timer_clear)
    else $error("slot write without accumulated sample");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> write_index == 4'd0 && write_value == 32'd0)
    else $error("write fields not zero without a write");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("new request taken while one is in progress");

endmodule
`default_nettype wire
